// ----- sv/fwr_pkg.sv -----
// shared types and constants for the firmware image receiver
`default_nettype none
package fwr_pkg;
	localparam int HeaderMaxDef = 16;
	localparam int PageBytesDef = 256;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_BYTE  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [3:0] ST_IGNORED  = 4'd0;
	localparam logic [3:0] ST_HDR_BYTE = 4'd1;
	localparam logic [3:0] ST_LEN_OK   = 4'd2;
	localparam logic [3:0] ST_LEN_BAD  = 4'd3;
	localparam logic [3:0] ST_DATA     = 4'd4;
	localparam logic [3:0] ST_HINT     = 4'd5;
	localparam logic [3:0] ST_DONE     = 4'd6;
	localparam logic [3:0] ST_TIMEOUT  = 4'd7;
	localparam logic [3:0] ST_OVERFLOW = 4'd8;
	localparam logic [3:0] ST_STARTED  = 4'd9;
	localparam logic [3:0] ST_TICK     = 4'd10;

	localparam logic [1:0] REG_MAX_IMAGE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_HINT      = 2'd2;

	localparam logic [20:0] ValCap = 21'h1FFFFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PARSE,
		S_DIV_INIT,
		S_DIV,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- sv/firmware_image_receiver.sv -----
// top level of the firmware image receiver: event decode, header parse, percent divider
// flow: start, tick and data items are decoded, then pass the divider init and, when a length
// is held, the divider steps; a header line end first runs the parser over the stored bytes
// throughput: one item at a time, set by the shared restoring divider (one quotient bit
// per cycle) and the byte-serial header parser
// reset: asynchronous, idle with no session, registers at their documented defaults
`default_nettype none
module firmware_image_receiver #(
	parameter int HEADER_MAX = fwr_pkg::HeaderMaxDef,
	parameter int PAGE_BYTES = fwr_pkg::PageBytesDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic [7:0]       data_out,
	output logic [11:0]      page_index,
	output logic [7:0]       page_offset,
	output logic             page_ready,
	output logic [20:0]      received_total,
	output logic [19:0]      expected_total,
	output logic [6:0]       progress_percent,
	output logic [20:0]      aligned_length,
	output logic [7:0]       tail_bytes
);
	import fwr_pkg::*;

	localparam int HcW = $clog2(HEADER_MAX + 1);
	localparam int HiW = $clog2(HEADER_MAX);
	localparam int PfW = $clog2(PAGE_BYTES);
	localparam int DivN = 28;
	localparam int DcW = $clog2(DivN + 1);

	// configuration
	logic [19:0] max_img_q;
	logic [15:0] timeout_q, hint_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_img_q <= 20'd983040;
			timeout_q <= 16'd10000;
			hint_q    <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_IMAGE: max_img_q <= cfg_data;
				REG_TIMEOUT:   timeout_q <= cfg_data[15:0];
				REG_HINT:      hint_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// header memory
	logic [7:0] hdr_mem [HEADER_MAX];
	logic [7:0] hdr_rd_q;
	logic hdr_we;
	logic [HiW-1:0] hdr_wa, hdr_ra;
	always_ff @(posedge clk) begin
		if (hdr_we) hdr_mem[hdr_wa] <= rx_byte;
		hdr_rd_q <= hdr_mem[hdr_ra];
	end

	state_t state_q, state_d;
	logic receiving_q, hdr_done_q, hint_given_q;
	logic [HcW-1:0] hdr_cnt_q;
	logic [20:0] total_q;
	logic [11:0] page_q;
	logic [PfW-1:0] fill_q;
	logic [19:0] decl_q;
	logic [15:0] idle_q;

	// parser state
	logic [HcW-1:0] pk_q;
	logic [20:0] val_q;
	logic pstop_q, pbad_q;

	// divider state
	logic [27:0] dnum_q;
	logic [20:0] drem_q;
	logic [27:0] dquo_q;
	logic [DcW-1:0] dcnt_q;

	// result registers
	logic [3:0] r_status_q;
	logic [7:0] r_data_q, r_off_q, r_tail_q;
	logic [11:0] r_pidx_q;
	logic r_pready_q;
	logic [20:0] r_align_q;

	logic accept;
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign hdr_wa = hdr_cnt_q[HiW-1:0];

	// divider step
	logic [21:0] dtrial;
	assign dtrial = {drem_q, dnum_q[27]} - {2'b0, decl_q};

	// parser step on the registered header byte
	logic [7:0] pc;
	logic is_digit;
	logic [24:0] val_mul;
	logic [24:0] val_next;
	assign pc = hdr_rd_q;
	assign is_digit = (pc >= 8'h30) && (pc <= 8'h39);
	assign val_mul = {1'b0, val_q, 3'b0} + {3'b0, val_q, 1'b0};
	assign val_next = val_mul + {21'd0, pc[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			receiving_q <= 1'b0;
			hdr_done_q <= 1'b0;
			hint_given_q <= 1'b0;
			hdr_cnt_q <= '0;
			total_q <= '0;
			page_q <= '0;
			fill_q <= '0;
			decl_q <= '0;
			idle_q <= '0;
			r_status_q <= ST_IGNORED;
			pk_q <= '0;
			val_q <= '0;
			pstop_q <= 1'b0;
			pbad_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: if (accept) begin
					r_data_q <= '0; r_pidx_q <= '0; r_off_q <= '0;
					r_pready_q <= 1'b0; r_align_q <= '0; r_tail_q <= '0;
					r_status_q <= ST_IGNORED;
					if (func == FUNC_START) begin
						if (!receiving_q) begin
							receiving_q <= 1'b1; hdr_done_q <= 1'b0; hint_given_q <= 1'b0;
							hdr_cnt_q <= '0; total_q <= '0; page_q <= '0; fill_q <= '0;
							decl_q <= '0; idle_q <= '0;
							r_status_q <= ST_STARTED;
						end
					end else if (func == FUNC_BYTE && receiving_q) begin
						idle_q <= '0;
						if (!hdr_done_q) begin
							hdr_cnt_q <= hdr_cnt_q + 1'b1;
							if (rx_byte == 8'h0A || hdr_cnt_q + 1'b1 >= HcW'(HEADER_MAX)) begin
								hdr_done_q <= 1'b1;
								pk_q <= '0; val_q <= '0; pstop_q <= 1'b0; pbad_q <= 1'b0;
							end else begin
								r_status_q <= ST_HDR_BYTE;
							end
						end else if (total_q + 21'd1 > {1'b0, max_img_q}) begin
							total_q <= total_q + 21'd1;
							receiving_q <= 1'b0;
							r_status_q <= ST_OVERFLOW;
						end else begin
							r_data_q <= rx_byte;
							r_pidx_q <= page_q;
							r_off_q <= 8'(fill_q);
							total_q <= total_q + 21'd1;
							if (fill_q == PfW'(PAGE_BYTES - 1)) begin
								r_pready_q <= 1'b1;
								page_q <= page_q + 12'd1;
								fill_q <= '0;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
							r_status_q <= ST_DATA;
							if (decl_q != '0 && total_q + 21'd1 >= {1'b0, decl_q}) begin
								r_status_q <= ST_DONE;
								receiving_q <= 1'b0;
								r_align_q <= (total_q + 21'd4) & ~21'd3;
								r_tail_q <= (fill_q == PfW'(PAGE_BYTES - 1)) ? 8'd0
									: 8'(fill_q + 1'b1);
							end
						end
					end else if (func == FUNC_TICK && receiving_q) begin
						logic [15:0] ic;
						ic = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
						idle_q <= ic;
						if (ic > hint_q && total_q != '0 && !hint_given_q) begin
							hint_given_q <= 1'b1;
							r_status_q <= ST_HINT;
						end else if (ic > timeout_q) begin
							receiving_q <= 1'b0;
							r_status_q <= ST_TIMEOUT;
						end else begin
							r_status_q <= ST_TICK;
						end
					end
				end
				// one header byte per cycle, memory read address leading the parse index by one
				S_PARSE: begin
					if (pk_q >= 4 && pk_q < hdr_cnt_q && !pstop_q) begin
						if (is_digit) begin
							val_q <= (val_next > 25'(ValCap)) ? ValCap : val_next[20:0];
						end else if (pc == 8'h0D || pc == 8'h0A) begin
							pstop_q <= 1'b1;
						end else begin
							pstop_q <= 1'b1; pbad_q <= 1'b1;
						end
					end else if (pk_q < 4) begin
						if ((pk_q == 0 && pc != 8'h4C) || (pk_q == 1 && pc != 8'h45)
							|| (pk_q == 2 && pc != 8'h4E) || (pk_q == 3 && pc != 8'h3A))
							pbad_q <= 1'b1;
					end
					pk_q <= pk_q + 1'b1;
					if (state_d != S_PARSE) begin
						logic [20:0] v;
						v = (pbad_q || hdr_cnt_q < 5) ? 21'd0 : val_q;
						if (v >= 21'd16 && v <= {1'b0, max_img_q}) begin
							decl_q <= v[19:0];
							r_status_q <= ST_LEN_OK;
						end else begin
							r_status_q <= ST_LEN_BAD;
						end
					end
				end
				S_DIV_INIT: begin
					dnum_q <= 28'(total_q) * 28'd100;
					drem_q <= '0;
					dquo_q <= '0;
					dcnt_q <= '0;
				end
				// restoring division, one quotient bit per cycle
				S_DIV: begin
					dnum_q <= {dnum_q[26:0], 1'b0};
					if (!dtrial[21]) begin
						drem_q <= dtrial[20:0];
						dquo_q <= {dquo_q[26:0], 1'b1};
					end else begin
						drem_q <= {drem_q[19:0], dnum_q[27]};
						dquo_q <= {dquo_q[26:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 1'b1;
				end
				S_OUT: ;
				default: ;
			endcase
		end
	end

	// parse ends when all stored bytes are seen (the header read address leads by one)
	logic parse_end;
	assign parse_end = (pk_q == hdr_cnt_q) || (pk_q == HcW'(HEADER_MAX));
	// or once the line is known to stop early or to be malformed
	logic parse_last;
	assign parse_last = pbad_q || pstop_q;

	// next state, memory addressing
	always_comb begin
		state_d = state_q;
		hdr_we = 1'b0;
		hdr_ra = '0;
		unique case (state_q)
			S_IDLE: begin
				hdr_we = accept && func == FUNC_BYTE && receiving_q && !hdr_done_q
					&& hdr_cnt_q < HcW'(HEADER_MAX);
				if (accept) begin
					if (func == FUNC_BYTE && receiving_q && !hdr_done_q
						&& (rx_byte == 8'h0A || hdr_cnt_q + 1'b1 >= HcW'(HEADER_MAX)))
						state_d = S_PARSE;
					else
						state_d = S_DIV_INIT;
				end
			end
			S_PARSE: begin
				hdr_ra = HiW'(pk_q + 1'b1);
				if (parse_last || parse_end) state_d = S_DIV_INIT;
			end
			S_DIV_INIT: state_d = (decl_q != '0) ? S_DIV : S_OUT;
			S_DIV: if (dcnt_q == DcW'(DivN - 1)) state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	assign out_valid = (state_q == S_OUT);
	assign status = r_status_q;
	assign data_out = r_data_q;
	assign page_index = r_pidx_q;
	assign page_offset = r_off_q;
	assign page_ready = r_pready_q;
	assign received_total = total_q;
	assign expected_total = decl_q;
	assign progress_percent = (decl_q == '0) ? 7'd0
		: (dquo_q > 28'd100) ? 7'd100 : dquo_q[6:0];
	assign aligned_length = r_align_q;
	assign tail_bytes = r_tail_q;
endmodule
`default_nettype wire
